### sv/rrps_pkg.sv
// ----------------------------------------------------------------------------
// rrps_pkg
// Types and constants shared by the row range page span splitter: request,
// result and queue entry layouts, opcodes, status codes and register indexes.
// ----------------------------------------------------------------------------
package rrps_pkg;

   // Field widths fixed by the interface
   localparam int ROW_BITS    = 40;
   localparam int ENTRY_BITS  = 7;
   localparam int PAGE_BITS   = 6;
   localparam int COLUMN_BITS = 32;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;

   // Opcodes of a request
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_SPAN  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd2;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMN_ID  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAGE_COUNT = 1'b1;

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                  opcode;
      logic [ENTRY_BITS-1:0] entry_index;
      logic [ROW_BITS-1:0]   entry_row;
      logic [ROW_BITS-1:0]   row_start;
      logic [ROW_BITS-1:0]   row_count;
   } rrps_req_type;

   typedef struct packed {
      logic [COLUMN_BITS-1:0] column_out;
      logic [PAGE_BITS-1:0]   page_number;
      logic [ROW_BITS-1:0]    page_first_row;
      logic [ROW_BITS-1:0]    offset_in_page;
      logic [ROW_BITS-1:0]    span_rows;
      logic [STATUS_BITS-1:0] status;
      logic                   last;
   } rrps_rsp_type;

   // Classified request as it waits in the queue
   typedef struct packed {
      logic                  is_query;
      logic [ENTRY_BITS-1:0] slot;
      logic [ROW_BITS-1:0]   row;
      logic [ROW_BITS-1:0]   row_end;
      logic                  overflow;
   } rrps_cmd_type;

endpackage

### sv/rrps_front.sv
// ----------------------------------------------------------------------------
// rrps_front
// Accepts requests, drops loads aimed beyond the table, and works out the end
// row of a query together with its carry out before queueing it.
// ----------------------------------------------------------------------------
module rrps_front #(
   parameter int MAX_PAGES = 64
) (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rrps_pkg::rrps_req_type req_data,
   input  logic                  queue_full,
   output logic                  queue_push,
   output rrps_pkg::rrps_cmd_type queue_data
);
   import rrps_pkg::*;

   logic [ROW_BITS:0] range_sum;
   logic              is_query;
   logic              slot_ok;

   // A request is taken whenever the queue has room
   assign req_ready = !queue_full;

   // Range end with carry; the carry marks a range beyond the row space
   assign range_sum = {1'b0, req_data.row_start} + {1'b0, req_data.row_count};
   assign is_query  = (req_data.opcode == OP_QUERY);
   assign slot_ok   = (int'(req_data.entry_index) <= MAX_PAGES);

   // Loads to a slot outside the table are accepted and dropped here
   assign queue_push = req_valid && !queue_full && (is_query || slot_ok);

   always_comb begin
      queue_data.is_query = is_query;
      queue_data.slot     = req_data.entry_index;
      queue_data.row      = is_query ? req_data.row_start : req_data.entry_row;
      queue_data.row_end  = range_sum[ROW_BITS-1:0];
      queue_data.overflow = range_sum[ROW_BITS];
   end

endmodule

### sv/rrps_queue.sv
// ----------------------------------------------------------------------------
// rrps_queue
// Short first-in first-out queue of classified requests between the front
// and back parts, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module rrps_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rrps_pkg::rrps_cmd_type push_data,
   output logic                   full,
   input  logic                   pop,
   output rrps_pkg::rrps_cmd_type pop_data,
   output logic                   not_empty
);
   import rrps_pkg::*;

   rrps_cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]   count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/rrps_back.sv
// ----------------------------------------------------------------------------
// rrps_back
// Holds the page start table and carries out queued requests: writes loads,
// and for a query scans the table for the start page, walks the pages and sends
// one result per overlapping page (or one status result) via an output register.
// ----------------------------------------------------------------------------
module rrps_back #(
   parameter int MAX_PAGES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   input  rrps_pkg::rrps_cmd_type             cmd,
   output logic                               cmd_pop,
   input  logic [rrps_pkg::COLUMN_BITS-1:0]   column_id,
   input  logic [rrps_pkg::COUNT_BITS-1:0]    page_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rrps_pkg::rrps_rsp_type             rsp_data
);
   import rrps_pkg::*;

   localparam int DEPTH = MAX_PAGES + 1;
   localparam int IW    = $clog2(MAX_PAGES + 1);
   localparam int CW    = $clog2(MAX_PAGES + 2);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_WREAD  = 3'd3;
   localparam logic [2:0] ST_WEVAL  = 3'd4;
   localparam logic [2:0] ST_WEMIT  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   // Table storage and its two registered read ports
   logic [ROW_BITS-1:0] page_mem [DEPTH];
   logic [ROW_BITS-1:0] rd_a_ff, rd_b_ff;
   logic [IW-1:0]       addr_a, addr_b;
   logic                mem_we;

   // Control state
   logic [2:0]          state_ff, state_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Query working registers
   logic [ROW_BITS-1:0] start_ff, start_in;
   logic [ROW_BITS-1:0] end_ff, end_in;
   logic                ovf_ff, ovf_in;
   logic [IW-1:0]       scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                err_ff, err_in;
   logic                at_end_ff, at_end_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [ROW_BITS-1:0] pb_ff, pb_in;
   logic [ROW_BITS-1:0] ob_ff, ob_in;
   logic [ROW_BITS-1:0] oe_ff, oe_in;
   rrps_rsp_type        pend_ff, pend_in;
   rrps_rsp_type        rsp_ff, rsp_in;

   logic [IW-1:0]       pc;
   logic                out_free;
   logic                push;
   rrps_rsp_type        push_data;
   rrps_rsp_type        span;

   // Result carrying only a status, used for the empty and error cases
   function automatic rrps_rsp_type blank_result(
      input logic [COLUMN_BITS-1:0] column,
      input logic [STATUS_BITS-1:0] code
   );
      rrps_rsp_type result;
      result                = '0;
      result.column_out     = column;
      result.status         = code;
      result.last           = 1'b1;
      return result;
   endfunction

   // Page count in use, limited to the table size
   assign pc = (int'(page_count) > MAX_PAGES) ? IW'(MAX_PAGES) : IW'(page_count);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Span of the page under evaluation
   always_comb begin
      span                = '0;
      span.column_out     = column_id;
      span.page_number    = PAGE_BITS'(idx_ff);
      span.page_first_row = pb_ff;
      span.offset_in_page = ob_ff - pb_ff;
      span.span_rows      = oe_ff - ob_ff;
      span.status         = STATUS_SPAN;
      span.last           = 1'b0;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      pend_valid_in = pend_valid_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      ovf_in        = ovf_ff;
      scan_ptr_in   = scan_ptr_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      at_end_in     = at_end_ff;
      idx_in        = idx_ff;
      pb_in         = pb_ff;
      ob_in         = ob_ff;
      oe_in         = oe_ff;
      pend_in       = pend_ff;
      addr_a        = scan_ptr_ff;
      addr_b        = pc;
      mem_we        = 1'b0;
      cmd_pop       = 1'b0;
      push          = 1'b0;
      push_data     = pend_ff;

      case (state_ff)
         ST_IDLE: begin
            // Entry 0 and the last entry are read while the query is taken
            addr_a = '0;
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.is_query) begin
                  start_in    = cmd.row;
                  end_in      = cmd.row_end;
                  ovf_in      = cmd.overflow;
                  scan_ptr_in = '0;
                  cnt_in      = '0;
                  state_in    = ST_SCAN;
               end else begin
                  mem_we = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // Count entries not above the start row, one per cycle
            cnt_in = cnt_ff + CW'(rd_a_ff <= start_ff);
            if (scan_ptr_ff == pc) begin
               err_in    = ovf_ff || (end_ff > rd_b_ff);
               at_end_in = (start_ff == rd_b_ff);
               state_in  = ST_START;
            end else begin
               addr_a      = scan_ptr_ff + IW'(1);
               scan_ptr_in = scan_ptr_ff + IW'(1);
            end
         end
         ST_START: begin
            if (err_ff) begin
               if (out_free) begin
                  push      = 1'b1;
                  push_data = blank_result(column_id, STATUS_RANGE);
                  state_in  = ST_IDLE;
               end
            end else begin
               if (at_end_ff) begin
                  idx_in = pc;
               end else if (cnt_ff == '0) begin
                  idx_in = '0;
               end else begin
                  idx_in = IW'(cnt_ff - CW'(1));
               end
               pend_valid_in = 1'b0;
               state_in      = ST_WREAD;
            end
         end
         ST_WREAD: begin
            // Fetch the page start and the next entry
            addr_a = idx_ff;
            if (idx_ff < pc) begin
               addr_b   = idx_ff + IW'(1);
               state_in = ST_WEVAL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WEVAL: begin
            pb_in    = rd_a_ff;
            ob_in    = (start_ff > rd_a_ff) ? start_ff : rd_a_ff;
            oe_in    = (end_ff < rd_b_ff) ? end_ff : rd_b_ff;
            state_in = (rd_a_ff < end_ff) ? ST_WEMIT : ST_FINISH;
         end
         ST_WEMIT: begin
            // A found span is held back until the next one shows it is not last
            if (ob_ff < oe_ff) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     push = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = span;
                  idx_in        = idx_ff + IW'(1);
                  state_in      = ST_WREAD;
               end
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_WREAD;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               push = 1'b1;
               if (pend_valid_ff) begin
                  push_data      = pend_ff;
                  push_data.last = 1'b1;
               end else begin
                  push_data = blank_result(column_id, STATUS_EMPTY);
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = push_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      end_ff      <= end_in;
      ovf_ff      <= ovf_in;
      scan_ptr_ff <= scan_ptr_in;
      cnt_ff      <= cnt_in;
      err_ff      <= err_in;
      at_end_ff   <= at_end_in;
      idx_ff      <= idx_in;
      pb_ff       <= pb_in;
      ob_ff       <= ob_in;
      oe_ff       <= oe_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   // Table memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[IW'(cmd.slot)] <= cmd.row;
      end
      rd_a_ff <= page_mem[addr_a];
      rd_b_ff <= page_mem[addr_b];
   end

endmodule

### sv/row_range_page_span_splitter.sv
// ----------------------------------------------------------------------------
// row_range_page_span_splitter
// Splits a row range into per-page spans over a loaded table of page start
// rows; also holds the column and page count registers.
//
//   channel  direction  payload          taken when
//   req_     in         rrps_req_type    req_valid & req_ready
//   rsp_     out        rrps_rsp_type    rsp_valid & rsp_ready
//   csr_     in         index, data      csr_valid & csr_ready
//
// The back part writes a load from idle; a query searches the table for its start
// page and walks the pages, reading and evaluating each and emitting those that
// overlap; a range error gives one status result after the search instead. The
// start page search reads one entry a cycle. Reset clears the control state and
// the column register and sets the page count to one; the table is undefined until
// loaded. Requests queue two deep, so the front takes two while the back stalls.
// ----------------------------------------------------------------------------
module row_range_page_span_splitter #(
   parameter int MAX_PAGES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  rrps_pkg::rrps_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rrps_pkg::rrps_rsp_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rrps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rrps_pkg::COLUMN_BITS-1:0]     csr_data
);
   import rrps_pkg::*;

   logic [COLUMN_BITS-1:0] column_id_ff, column_id_in;
   logic [COUNT_BITS-1:0]  page_count_ff, page_count_in;
   logic                   queue_full;
   logic                   queue_push;
   rrps_cmd_type           queue_in_data;
   logic                   queue_pop;
   logic                   queue_not_empty;
   rrps_cmd_type           queue_out_data;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      column_id_in  = column_id_ff;
      page_count_in = page_count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COLUMN_ID:  column_id_in  = csr_data;
            CSR_PAGE_COUNT: page_count_in = csr_data[COUNT_BITS-1:0];
            default: begin
               column_id_in = column_id_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_id_ff  <= '0;
         page_count_ff <= COUNT_BITS'(1);
      end else begin
         column_id_ff  <= column_id_in;
         page_count_ff <= page_count_in;
      end
   end

   rrps_front #(
      .MAX_PAGES (MAX_PAGES)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (queue_in_data)
   );

   rrps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_in_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_out_data),
      .not_empty (queue_not_empty)
   );

   rrps_back #(
      .MAX_PAGES (MAX_PAGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_not_empty),
      .cmd        (queue_out_data),
      .cmd_pop    (queue_pop),
      .column_id  (column_id_ff),
      .page_count (page_count_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### sv/rrps_checker.sv
// ----------------------------------------------------------------------------
// rrps_port_checks
// Port-level checks on the result channel of the page span splitter, bound
// to the top level.
// ----------------------------------------------------------------------------
module rrps_port_checks (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rrps_pkg::rrps_rsp_type rsp_data
);
   import rrps_pkg::*;

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // Empty and error results close the request and carry no span
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_SPAN) |->
         rsp_data.last && (rsp_data.page_number == '0) &&
         (rsp_data.page_first_row == '0) && (rsp_data.offset_in_page == '0) &&
         (rsp_data.span_rows == '0))
      else $error("status result with span fields or without last");

   // A span always covers at least one row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_SPAN) |-> (rsp_data.span_rows != '0))
      else $error("span result of zero rows");

endmodule

bind row_range_page_span_splitter rrps_port_checks u_rrps_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/rrps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrps_checker
// Watches the request, result and register channels of the page span
// splitter. It keeps its own copy of the page start table and of the
// registers, works out the spans that each accepted query must give, and
// compares every accepted result field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module rrps_checker #(
   parameter int MAX_PAGES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  rrps_pkg::rrps_req_type              req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  rrps_pkg::rrps_rsp_type              rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rrps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rrps_pkg::COLUMN_BITS-1:0]    csr_data,
   output int                                  fail_count,
   output int                                  outstanding
);
   import rrps_pkg::*;

   // Mirror of the block's table and registers
   logic [ROW_BITS-1:0]    page_rows [0:MAX_PAGES];
   logic [COLUMN_BITS-1:0] column_reg;
   logic [COUNT_BITS-1:0]  page_count_reg;

   // Spans still to come, oldest first
   rrps_rsp_type span_expect_q[$];

   // Builds one result carrying the current column number.
   function automatic rrps_rsp_type make_span(input int unsigned page,
                                              input logic [ROW_BITS-1:0] first,
                                              input logic [ROW_BITS-1:0] offset,
                                              input logic [ROW_BITS-1:0] rows,
                                              input logic [STATUS_BITS-1:0] code,
                                              input logic is_last);
      rrps_rsp_type one;
      one.column_out     = column_reg;
      one.page_number    = page[PAGE_BITS-1:0];
      one.page_first_row = first;
      one.offset_in_page = offset;
      one.span_rows      = rows;
      one.status         = code;
      one.last           = is_last;
      return one;
   endfunction

   // Appends one result to the back of the expected list.
   function automatic void add_expected(input rrps_rsp_type one);
      span_expect_q.insert(span_expect_q.size(), one);
   endfunction

   // Applies one accepted request: a load updates the table, a query queues
   // the spans it must give.
   function automatic void predict_spans(input rrps_req_type item);
      int unsigned         pc;
      int unsigned         idx;
      int unsigned         upper;
      logic [ROW_BITS:0]   sum;
      logic [ROW_BITS-1:0] start;
      logic [ROW_BITS-1:0] stop;
      logic [ROW_BITS-1:0] back;
      logic [ROW_BITS-1:0] pb;
      logic [ROW_BITS-1:0] pe;
      logic [ROW_BITS-1:0] ob;
      logic [ROW_BITS-1:0] oe;
      rrps_rsp_type        held;
      bit                  have_held;

      if (item.opcode == OP_LOAD) begin
         // Slots past the end of the table are dropped.
         if (item.entry_index <= MAX_PAGES)
            page_rows[item.entry_index] = item.entry_row;
         return;
      end

      pc    = (page_count_reg > MAX_PAGES) ? MAX_PAGES : page_count_reg;
      start = item.row_start;
      back  = page_rows[pc];
      sum   = {1'b0, item.row_start} + {1'b0, item.row_count};

      // A range that wraps the row width or runs past the table end
      if (sum[ROW_BITS] || sum[ROW_BITS-1:0] > back) begin
         add_expected(make_span(0, '0, '0, '0, STATUS_RANGE, 1'b1));
         return;
      end
      stop = sum[ROW_BITS-1:0];

      // Start page: entries not above the start row, less one.
      upper = 0;
      for (int i = 0; i <= pc; i++)
         if (page_rows[i] <= start)
            upper++;
      if (start == back)
         idx = pc;
      else if (upper == 0)
         idx = 0;
      else
         idx = upper - 1;

      // Walk forward, holding back each span until the next one shows whether
      // it is the final one.
      have_held = 1'b0;
      while (idx < pc && page_rows[idx] < stop) begin
         pb = page_rows[idx];
         pe = page_rows[idx + 1];
         ob = (start > pb) ? start : pb;
         oe = (stop < pe) ? stop : pe;
         if (ob < oe) begin
            if (have_held)
               add_expected(held);
            held      = make_span(idx, pb, ob - pb, oe - ob, STATUS_SPAN, 1'b0);
            have_held = 1'b1;
         end
         idx++;
      end

      if (have_held) begin
         held.last = 1'b1;
         add_expected(held);
      end else begin
         add_expected(make_span(0, '0, '0, '0, STATUS_EMPTY, 1'b1));
      end
   endfunction

   // Compares one field and reports a difference.
   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: result field %s mismatch: expected %h, actual %h",
                  $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Observe all three channels at the rising edge.
   always @(posedge clock) begin
      rrps_rsp_type want;
      if (reset) begin
         column_reg     = '0;
         page_count_reg = 7'd1;
         span_expect_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (span_expect_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = span_expect_q.pop_front();
               check_field("column_out", 64'(want.column_out),
                           64'(rsp_data.column_out));
               check_field("page_number", 64'(want.page_number),
                           64'(rsp_data.page_number));
               check_field("page_first_row", 64'(want.page_first_row),
                           64'(rsp_data.page_first_row));
               check_field("offset_in_page", 64'(want.offset_in_page),
                           64'(rsp_data.offset_in_page));
               check_field("span_rows", 64'(want.span_rows),
                           64'(rsp_data.span_rows));
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("last", 64'(want.last), 64'(rsp_data.last));
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COLUMN_ID:  column_reg = csr_data;
               CSR_PAGE_COUNT: page_count_reg = csr_data[COUNT_BITS-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready)
            predict_spans(req_data);
      end
      outstanding = span_expect_q.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the row range page span splitter. Loads page tables of
// mixed page sizes, writes the column and page count registers between
// phases, and sends directed and random queries with random gaps on both
// channels. Checking is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module tb_top;
   import rrps_pkg::*;

   localparam int                  MAX_PAGES       = 64;
   localparam int                  RANDOM_ITEMS    = 330;
   localparam int                  SETTLE_CYCLES   = 400;
   localparam int                  RSP_HOLD_CYCLES = 800;
   localparam int                  STALL_LIMIT     = 5000;
   localparam int                  PRESSURE_PHASE  = 3;
   localparam logic [ROW_BITS-1:0] ROW_MAX         = '1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   rrps_req_type              req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rrps_rsp_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_COLUMN_ID;
   logic [COLUMN_BITS-1:0]    csr_data = '0;
   int                        fail_count;
   int                        outstanding;

   // Set by the request side, read by the result side
   bit quiet    = 1'b0;
   bit hold_rsp = 1'b0;

   // Table as loaded, used only to shape the queries and entry rewrites
   logic [ROW_BITS-1:0] shadow_rows [0:MAX_PAGES];

   row_range_page_span_splitter #(.MAX_PAGES(MAX_PAGES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rrps_checker #(.MAX_PAGES(MAX_PAGES)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Clock generation
   initial begin
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   function automatic logic [ROW_BITS-1:0] random_row();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[ROW_BITS-1:0];
   endfunction

   // Random value in 0..limit
   function automatic logic [ROW_BITS-1:0] random_upto(input logic [ROW_BITS-1:0] limit);
      logic [63:0] r;
      logic [63:0] m;
      r = {$urandom(), $urandom()};
      if (&limit)
         return r[ROW_BITS-1:0];
      m = r % ({24'd0, limit} + 64'd1);
      return m[ROW_BITS-1:0];
   endfunction

   // Load request; the query fields carry random noise.
   function automatic rrps_req_type load_item(input int unsigned slot,
                                              input logic [ROW_BITS-1:0] row);
      rrps_req_type item;
      item.opcode      = OP_LOAD;
      item.entry_index = slot[ENTRY_BITS-1:0];
      item.entry_row   = row;
      item.row_start   = random_row();
      item.row_count   = random_row();
      return item;
   endfunction

   // Query request; the load fields carry random noise.
   function automatic rrps_req_type query_item(input logic [ROW_BITS-1:0] start,
                                               input logic [ROW_BITS-1:0] count);
      rrps_req_type item;
      logic [31:0]  noise;
      noise            = $urandom();
      item.opcode      = OP_QUERY;
      item.entry_index = noise[ENTRY_BITS-1:0];
      item.entry_row   = random_row();
      item.row_start   = start;
      item.row_count   = count;
      return item;
   endfunction

   // Offers one request after a gap and returns at the edge that takes it.
   task automatic send_request(input rrps_req_type item);
      int gap;
      gap = idle_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_load(input int unsigned slot, input logic [ROW_BITS-1:0] row);
      if (slot <= MAX_PAGES)
         shadow_rows[slot] = row;
      send_request(load_item(slot, row));
   endtask

   // Register write, only ever issued while the block is idle
   task automatic send_csr(input logic [CSR_INDEX_BITS-1:0] index,
                           input logic [COLUMN_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops offering requests, waits for every result and lets a last load
   // work through the block.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Result side: random back-pressure, plus one long hold when asked.
   initial begin : rsp_side
      int stall;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            stall = idle_gap();
            if (stall == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   // Watchdog: too long without any channel moving ends the run.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("row_range_page_span_splitter regression: fail");
      $finish;
   end

   // Stimulus and verdict
   initial begin : stimulus
      int                  phase;
      int                  item_total;
      int unsigned         pc_reg;
      int unsigned         pc_eff;
      int unsigned         nq;
      int unsigned         pick;
      int unsigned         sel;
      int unsigned         k;
      int unsigned         j;
      int unsigned         rot;
      int unsigned         roll;
      logic [31:0]         word;
      logic [63:0]         rel [0:MAX_PAGES];
      logic [63:0]         size;
      logic [ROW_BITS-1:0] base;
      logic [ROW_BITS-1:0] back;
      logic [ROW_BITS-1:0] start;
      logic [ROW_BITS-1:0] count;
      logic [ROW_BITS-1:0] room;

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed part: small table with an empty page, edges of the range
      send_csr(CSR_COLUMN_ID, 32'hFFFF_FFFF);
      send_csr(CSR_PAGE_COUNT, 32'd4);
      send_load(0, 40'd0);
      send_load(1, 40'd10);
      send_load(2, 40'd10);
      send_load(3, 40'd25);
      send_load(4, 40'd40);
      // A slot past the table is ignored; the top slot is kept.
      send_load(127, ROW_MAX);
      send_load(MAX_PAGES, ROW_MAX);
      send_request(query_item(40'd0, 40'd40));
      send_request(query_item(40'd0, 40'd0));
      // Start row on the final entry
      send_request(query_item(40'd40, 40'd0));
      send_request(query_item(40'd12, 40'd5));
      send_request(query_item(40'd10, 40'd1));
      // Ranges past the end and ranges that wrap the row width
      send_request(query_item(40'd39, 40'd2));
      send_request(query_item(ROW_MAX, 40'd1));
      send_request(query_item(40'd0, ROW_MAX));
      send_request(query_item(ROW_MAX, 40'd0));
      // Out-of-order table entry
      send_load(2, 40'd30);
      send_request(query_item(40'd0, 40'd40));
      send_load(2, 40'd10);
      // No pages at all
      drain_results();
      send_csr(CSR_PAGE_COUNT, 32'd0);
      send_request(query_item(40'd0, 40'd0));
      send_request(query_item(40'd0, 40'd5));

      // Random phases, each with its own registers and table
      phase      = 0;
      item_total = 0;
      while (item_total < RANDOM_ITEMS) begin
         drain_results();
         @(posedge clock);
         quiet = (phase % 5 == 4) || (phase == PRESSURE_PHASE);

         send_csr(CSR_COLUMN_ID, (phase == 0) ? 32'd0 : $urandom());
         case (phase % 6)
            0:       pc_reg = MAX_PAGES;
            1:       pc_reg = $urandom_range(MAX_PAGES + 1, 127);
            2:       pc_reg = 1;
            3:       pc_reg = $urandom_range(9, MAX_PAGES - 1);
            default: pc_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         endcase
         pc_eff = (pc_reg > MAX_PAGES) ? MAX_PAGES : pc_reg;
         // Bits above the page count field carry noise.
         word = $urandom();
         word[COUNT_BITS-1:0] = pc_reg[COUNT_BITS-1:0];
         send_csr(CSR_PAGE_COUNT, word);

         // Page sizes: some empty, most small, a few very large.
         rel[0] = '0;
         for (int i = 0; i < pc_eff; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
               size = '0;
            else if (roll < 70)
               size = 64'($urandom_range(1, 64));
            else if (roll < 90)
               size = 64'($urandom_range(65, 100000));
            else
               size = 64'($urandom_range(32'hFFFF_FFFF, 32'h0010_0000));
            rel[i + 1] = rel[i] + size;
         end
         roll = $urandom_range(0, 9);
         if (roll < 5)
            base = '0;
         else if (roll < 7)
            base = ROW_BITS'($urandom_range(1, 100));
         else
            base = ROW_MAX - rel[pc_eff][ROW_BITS-1:0] - ROW_BITS'($urandom_range(0, 16));

         // Load the table in a rotated order, with the odd ignored slot.
         rot = $urandom_range(0, pc_eff);
         for (int i = 0; i <= pc_eff; i++) begin
            k = (i + rot) % (pc_eff + 1);
            send_load(k, base + rel[k][ROW_BITS-1:0]);
            item_total++;
            if ($urandom_range(0, 9) == 0)
               send_load($urandom_range(MAX_PAGES + 1, 127), random_row());
         end

         if (phase == PRESSURE_PHASE)
            hold_rsp = 1'b1;

         nq = $urandom_range(10, 20);
         for (int q = 0; q < nq; q++) begin
            pick  = $urandom_range(0, 99);
            back  = shadow_rows[pc_eff];
            k     = $urandom_range(0, pc_eff);
            start = shadow_rows[k];
            if (k < pc_eff && shadow_rows[k + 1] > start && $urandom_range(0, 2) != 0)
               start = start + random_upto(shadow_rows[k + 1] - start - 1);
            // Below the first entry when the table does not begin at zero
            if (shadow_rows[0] != 0 && $urandom_range(0, 4) == 0)
               start = random_upto(shadow_rows[0] - 1);
            room = (back >= start) ? back - start : '0;

            if (pick < 65) begin
               sel = $urandom_range(0, 6);
               if (sel == 0)
                  count = '0;
               else if (sel == 1)
                  count = room;
               else if (sel < 5)
                  count = random_upto(room);
               else
                  count = random_upto((room < 256) ? room : 40'd256);
               send_request(query_item(start, count));
               item_total++;
            end else if (pick < 77) begin
               send_request(query_item(start, room + 1 + $urandom_range(0, 3)));
               item_total++;
            end else if (pick < 85) begin
               send_request(query_item(random_row(), random_row()));
               item_total++;
            end else if (pick < 93 && pc_eff > 1) begin
               // Rewrite an inner entry, in order or out of order.
               j = $urandom_range(1, pc_eff - 1);
               if (shadow_rows[j + 1] >= shadow_rows[j - 1] && $urandom_range(0, 1) == 0)
                  send_load(j, shadow_rows[j - 1] +
                            random_upto(shadow_rows[j + 1] - shadow_rows[j - 1]));
               else
                  send_load(j, random_row());
               item_total++;
            end else begin
               send_load($urandom_range(MAX_PAGES + 1, 127), random_row());
            end
         end
         phase++;
      end

      drain_results();
      if (fail_count == 0 && outstanding == 0)
         $display("row_range_page_span_splitter regression: pass");
      else
         $display("row_range_page_span_splitter regression: fail");
      $finish;
   end

endmodule
